[design/i2cbb_pkg.sv]
package i2cbb_pkg;

    // default depth of the transmit queue and the receive buffer
    localparam int BUFFER_DEPTH_DEF = 32;

    // widths fixed by the item layout
    localparam int RES_CNT_W = 6;
    localparam int WAIT_W    = 16;
    localparam logic [3:0] BITS_PER_BYTE = 4'd8;

    typedef enum logic [2:0] {
        ACT_TICK  = 3'd0,
        ACT_BEGIN = 3'd1,
        ACT_QUEUE = 3'd2,
        ACT_END   = 3'd3,
        ACT_READ  = 3'd4,
        ACT_TAKE  = 3'd5
    } act_t;

    typedef enum logic [1:0] {
        STAT_OK       = 2'd0,
        STAT_ADDR_NAK = 2'd1,
        STAT_DATA_NAK = 2'd2
    } stat_t;

    typedef enum logic [4:0] {
        ST_IDLE,
        ST_START,
        ST_CHK,
        ST_CHKSDA,
        ST_RELSCL,
        ST_PULSDA,
        ST_PULSCL,
        ST_TXBIT,
        ST_TXW2,
        ST_TXRISE,
        ST_TXW4,
        ST_TXFALL,
        ST_TXA2,
        ST_TXAREL,
        ST_TXPOLL,
        ST_TXA5,
        ST_TXEND,
        ST_RXW2,
        ST_RXRISE,
        ST_RXW4,
        ST_RXFALL,
        ST_RXA2,
        ST_RXAREL,
        ST_RXA4,
        ST_RXEND,
        ST_SREL,
        ST_SDAREL,
        ST_DONE
    } step_t;

    // result fields known at the accepting edge (the rx byte joins from the receive buffer's registered read)
    typedef struct packed {
        logic                 scl_low;
        logic                 sda_low;
        logic                 busy;
        logic                 done;
        logic [1:0]           status;
        logic [RES_CNT_W-1:0] read_count;
        logic [RES_CNT_W-1:0] rx_left;
        logic [RES_CNT_W-1:0] tx_level;
    } res_t;

endpackage

[design/i2cbb_ram.sv]
module i2cbb_ram #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 32,
    localparam int AW = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
    input  logic             aclk,
    input  logic             we,
    input  logic [AW-1:0]    waddr,
    input  logic [WIDTH-1:0] wdata,
    input  logic             re,
    input  logic [AW-1:0]    raddr,
    output logic [WIDTH-1:0] rdata
);

    logic [WIDTH-1:0] mem [DEPTH];
    logic [WIDTH-1:0] rdata_reg;

    always_ff @(posedge aclk) begin
        if (we) begin
            mem[waddr] <= wdata;
        end
        if (re) begin
            rdata_reg <= mem[raddr];
        end
    end

    assign rdata = rdata_reg;

endmodule

[design/i2cbb_seq.sv]
module i2cbb_seq import i2cbb_pkg::*; #(
    parameter int BUFFER_DEPTH = BUFFER_DEPTH_DEF,
    localparam int IDX_W = (BUFFER_DEPTH > 1) ? $clog2(BUFFER_DEPTH) : 1,
    localparam int CNT_W = $clog2(BUFFER_DEPTH + 1)
) (
    input  logic              aclk,
    input  logic              aresetn,
    input  logic              accept,
    input  logic [2:0]        s_action,
    input  logic [7:0]        s_data_byte,
    input  logic [6:0]        s_address,
    input  logic [5:0]        s_count,
    input  logic              s_sda_in,
    input  logic              s_scl_in,
    input  logic              cfg_wr_en,
    input  logic [WAIT_W-1:0] cfg_wr_data,
    output logic              tx_we,
    output logic [IDX_W-1:0]  tx_waddr,
    output logic [7:0]        tx_wdata,
    output logic [IDX_W-1:0]  tx_raddr,
    input  logic [7:0]        tx_rdata,
    output logic              rx_we,
    output logic [IDX_W-1:0]  rx_waddr,
    output logic [7:0]        rx_wdata,
    output logic              rx_re,
    output logic [IDX_W-1:0]  rx_raddr,
    output res_t              res,
    output logic              take
);

    step_t             step_reg, step_next;
    logic [WAIT_W-1:0] wait_reg, wait_next;
    logic [WAIT_W-1:0] wt_reg, wt_next;
    logic              clk_reg, clk_next;
    logic              data_reg, data_next;
    logic [7:0]        shift_reg, shift_next;
    logic [3:0]        bit_reg, bit_next;
    logic [CNT_W-1:0]  bc_reg, bc_next;
    logic [CNT_W-1:0]  want_reg, want_next;
    logic [CNT_W-1:0]  txlen_reg, txlen_next;
    logic [CNT_W-1:0]  rxlen_reg, rxlen_next;
    logic [CNT_W-1:0]  rxidx_reg, rxidx_next;
    logic [6:0]        addr_reg, addr_next;
    logic              xmit_reg, xmit_next;
    logic              rd_reg, rd_next;
    logic              aphase_reg, aphase_next;
    logic              nak_reg, nak_next;
    stat_t             status_reg, status_next;

    act_t              act;
    logic [WAIT_W-1:0] reload;
    logic [CNT_W-1:0]  bc_inc;
    logic [CNT_W-1:0]  bc_wr;
    logic [3:0]        bit_inc;
    logic [7:0]        shift_sh;
    logic              done;

    assign act     = act_t'(s_action);
    // a zero wait setting acts as one
    assign reload  = (wt_reg == '0) ? '0 : wt_reg - WAIT_W'(1);
    assign bc_inc  = bc_reg + CNT_W'(1);
    assign bc_wr   = aphase_reg ? bc_reg : bc_inc;
    assign bit_inc = bit_reg + 4'd1;
    assign shift_sh = {shift_reg[6:0], 1'b0};

    // next byte to send, stable long before the ack slot ends
    assign tx_raddr = IDX_W'(bc_wr);

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            step_reg   <= ST_IDLE;
            wait_reg   <= '0;
            wt_reg     <= WAIT_W'(1);
            clk_reg    <= 1'b0;
            data_reg   <= 1'b0;
            shift_reg  <= '0;
            bit_reg    <= '0;
            bc_reg     <= '0;
            want_reg   <= '0;
            txlen_reg  <= '0;
            rxlen_reg  <= '0;
            rxidx_reg  <= '0;
            addr_reg   <= '0;
            xmit_reg   <= 1'b0;
            rd_reg     <= 1'b0;
            aphase_reg <= 1'b0;
            nak_reg    <= 1'b0;
            status_reg <= STAT_OK;
        end else begin
            step_reg   <= step_next;
            wait_reg   <= wait_next;
            wt_reg     <= wt_next;
            clk_reg    <= clk_next;
            data_reg   <= data_next;
            shift_reg  <= shift_next;
            bit_reg    <= bit_next;
            bc_reg     <= bc_next;
            want_reg   <= want_next;
            txlen_reg  <= txlen_next;
            rxlen_reg  <= rxlen_next;
            rxidx_reg  <= rxidx_next;
            addr_reg   <= addr_next;
            xmit_reg   <= xmit_next;
            rd_reg     <= rd_next;
            aphase_reg <= aphase_next;
            nak_reg    <= nak_next;
            status_reg <= status_next;
        end
    end

    always_comb begin
        step_next   = step_reg;
        wait_next   = wait_reg;
        wt_next     = wt_reg;
        clk_next    = clk_reg;
        data_next   = data_reg;
        shift_next  = shift_reg;
        bit_next    = bit_reg;
        bc_next     = bc_reg;
        want_next   = want_reg;
        txlen_next  = txlen_reg;
        rxlen_next  = rxlen_reg;
        rxidx_next  = rxidx_reg;
        addr_next   = addr_reg;
        xmit_next   = xmit_reg;
        rd_next     = rd_reg;
        aphase_next = aphase_reg;
        nak_next    = nak_reg;
        status_next = status_reg;
        tx_we       = 1'b0;
        tx_waddr    = IDX_W'(txlen_reg);
        tx_wdata    = s_data_byte;
        rx_we       = 1'b0;
        rx_waddr    = IDX_W'(bc_reg);
        rx_wdata    = shift_reg;
        rx_re       = 1'b0;
        rx_raddr    = IDX_W'(rxidx_reg);
        take        = 1'b0;
        done        = 1'b0;

        if (cfg_wr_en) begin
            wt_next = cfg_wr_data;
        end

        if (accept && act == ACT_TICK && step_reg != ST_IDLE) begin
            if (wait_reg != '0) begin
                wait_next = wait_reg - WAIT_W'(1);
            end else begin
                wait_next = reload;
                case (step_reg)
                    ST_START: step_next = ST_CHK;
                    ST_CHK: begin
                        if (s_scl_in && s_sda_in) begin
                            data_next = 1'b1;
                            step_next = ST_PULSCL;
                        end else if (s_scl_in) begin
                            clk_next  = 1'b1;
                            step_next = ST_CHKSDA;
                        end else if (!s_sda_in) begin
                            data_next = 1'b0;
                            step_next = ST_RELSCL;
                        end else begin
                            clk_next  = 1'b0;
                            step_next = ST_PULSDA;
                        end
                    end
                    ST_CHKSDA: begin
                        if (!s_sda_in) begin
                            data_next = 1'b0;
                            step_next = ST_RELSCL;
                        end else begin
                            clk_next  = 1'b0;
                            step_next = ST_PULSDA;
                        end
                    end
                    ST_RELSCL: begin
                        clk_next  = 1'b0;
                        step_next = ST_PULSDA;
                    end
                    ST_PULSDA: begin
                        data_next = 1'b1;
                        step_next = ST_PULSCL;
                    end
                    ST_PULSCL: begin
                        clk_next   = 1'b1;
                        shift_next = {addr_reg, rd_reg};
                        bit_next   = '0;
                        step_next  = ST_TXBIT;
                    end
                    ST_TXBIT: begin
                        data_next = !shift_reg[7];
                        step_next = ST_TXW2;
                    end
                    ST_TXW2: step_next = ST_TXRISE;
                    ST_TXRISE: begin
                        clk_next  = 1'b0;
                        step_next = ST_TXW4;
                    end
                    ST_TXW4: step_next = ST_TXFALL;
                    ST_TXFALL: begin
                        shift_next = shift_sh;
                        clk_next   = 1'b1;
                        bit_next   = bit_inc;
                        if (bit_inc < BITS_PER_BYTE) begin
                            data_next = !shift_sh[7];
                            step_next = ST_TXW2;
                        end else begin
                            step_next = ST_TXA2;
                        end
                    end
                    ST_TXA2: step_next = ST_TXAREL;
                    ST_TXAREL: begin
                        data_next = 1'b0;
                        clk_next  = 1'b0;
                        step_next = ST_TXPOLL;
                    end
                    ST_TXPOLL: begin
                        // slave may stretch the clock: poll until it is released
                        if (s_scl_in) begin
                            nak_next  = s_sda_in;
                            step_next = ST_TXA5;
                        end else begin
                            wait_next = '0;
                        end
                    end
                    ST_TXA5: step_next = ST_TXEND;
                    ST_TXEND: begin
                        clk_next  = 1'b1;
                        step_next = ST_SREL;
                        if (nak_reg) begin
                            if (!rd_reg) begin
                                status_next = aphase_reg ? STAT_ADDR_NAK : STAT_DATA_NAK;
                            end else begin
                                bc_next = '0;
                            end
                        end else if (rd_reg) begin
                            aphase_next = 1'b0;
                            if (bc_reg < want_reg) begin
                                data_next  = 1'b0;
                                shift_next = '0;
                                bit_next   = '0;
                                step_next  = ST_RXW2;
                            end
                        end else begin
                            aphase_next = 1'b0;
                            bc_next     = bc_wr;
                            if (bc_wr < txlen_reg && bc_wr < CNT_W'(BUFFER_DEPTH)) begin
                                shift_next = tx_rdata;
                                bit_next   = '0;
                                data_next  = !tx_rdata[7];
                                step_next  = ST_TXW2;
                            end else begin
                                status_next = STAT_OK;
                            end
                        end
                    end
                    ST_RXW2: step_next = ST_RXRISE;
                    ST_RXRISE: begin
                        clk_next   = 1'b0;
                        shift_next = {shift_reg[6:0], s_sda_in};
                        step_next  = ST_RXW4;
                    end
                    ST_RXW4: step_next = ST_RXFALL;
                    ST_RXFALL: begin
                        clk_next = 1'b1;
                        bit_next = bit_inc;
                        if (bit_inc < BITS_PER_BYTE) begin
                            step_next = ST_RXW2;
                        end else begin
                            // ack all but the last byte
                            data_next = bc_inc < want_reg;
                            step_next = ST_RXA2;
                        end
                    end
                    ST_RXA2: step_next = ST_RXAREL;
                    ST_RXAREL: begin
                        clk_next  = 1'b0;
                        step_next = ST_RXA4;
                    end
                    ST_RXA4: step_next = ST_RXEND;
                    ST_RXEND: begin
                        clk_next = 1'b1;
                        rx_we    = bc_reg < CNT_W'(BUFFER_DEPTH);
                        bc_next  = bc_inc;
                        if (bc_inc < want_reg) begin
                            data_next  = 1'b0;
                            shift_next = '0;
                            bit_next   = '0;
                            step_next  = ST_RXW2;
                        end else begin
                            data_next = 1'b1;
                            step_next = ST_SREL;
                        end
                    end
                    ST_SREL: begin
                        clk_next  = 1'b0;
                        step_next = ST_SDAREL;
                    end
                    ST_SDAREL: begin
                        data_next = 1'b0;
                        step_next = ST_DONE;
                    end
                    ST_DONE: begin
                        if (rd_reg) begin
                            rxlen_next = bc_reg;
                            rxidx_next = '0;
                        end else begin
                            txlen_next = '0;
                            xmit_next  = 1'b0;
                        end
                        done      = 1'b1;
                        wait_next = wait_reg;
                        step_next = ST_IDLE;
                    end
                    default: wait_next = wait_reg;
                endcase
            end
        end else if (accept && step_reg == ST_IDLE) begin
            case (act)
                ACT_BEGIN: begin
                    xmit_next  = 1'b1;
                    addr_next  = s_address;
                    txlen_next = '0;
                end
                ACT_QUEUE: begin
                    if (xmit_reg && txlen_reg < CNT_W'(BUFFER_DEPTH)) begin
                        tx_we      = 1'b1;
                        txlen_next = txlen_reg + CNT_W'(1);
                    end
                end
                ACT_END: begin
                    rd_next     = 1'b0;
                    aphase_next = 1'b1;
                    nak_next    = 1'b0;
                    bc_next     = '0;
                    wait_next   = '0;
                    step_next   = ST_START;
                end
                ACT_READ: begin
                    addr_next   = s_address;
                    want_next   = (32'(s_count) > BUFFER_DEPTH) ? CNT_W'(BUFFER_DEPTH)
                                                                : CNT_W'(s_count);
                    rxlen_next  = '0;
                    rxidx_next  = '0;
                    rd_next     = 1'b1;
                    aphase_next = 1'b1;
                    nak_next    = 1'b0;
                    bc_next     = '0;
                    wait_next   = '0;
                    step_next   = ST_START;
                end
                ACT_TAKE: begin
                    if (rxidx_reg < rxlen_reg && rxidx_reg < CNT_W'(BUFFER_DEPTH)) begin
                        rx_re      = 1'b1;
                        take       = 1'b1;
                        rxidx_next = rxidx_reg + CNT_W'(1);
                    end
                end
                default: ;
            endcase
        end

        res.scl_low    = clk_next;
        res.sda_low    = data_next;
        res.busy       = step_next != ST_IDLE;
        res.done       = done;
        res.status     = status_next;
        res.read_count = RES_CNT_W'(rxlen_next);
        res.rx_left    = (rxlen_next >= rxidx_next) ? RES_CNT_W'(rxlen_next - rxidx_next)
                                                    : '0;
        res.tx_level   = RES_CNT_W'(txlen_next);
    end

    a_idle_no_wait: assert property (@(posedge aclk) disable iff (!aresetn)
        step_reg == ST_IDLE |-> wait_reg == '0)
        else $error("wait counter running while idle");

    a_queue_when_idle: assert property (@(posedge aclk) disable iff (!aresetn)
        tx_we |-> step_reg == ST_IDLE && xmit_reg && txlen_reg < CNT_W'(BUFFER_DEPTH))
        else $error("transmit queue written outside an open write");

    a_rx_write_step: assert property (@(posedge aclk) disable iff (!aresetn)
        rx_we |=> rd_reg && bc_reg <= want_reg && (step_reg == ST_RXW2 || step_reg == ST_SREL))
        else $error("receive buffer written outside a read byte end");

    a_tx_level_bound: assert property (@(posedge aclk) disable iff (!aresetn)
        txlen_reg <= CNT_W'(BUFFER_DEPTH) && rxidx_reg <= rxlen_reg)
        else $error("buffer counts out of range");

endmodule

[design/i2cbb_out.sv]
module i2cbb_out import i2cbb_pkg::*; (
    input  logic       aclk,
    input  logic       aresetn,
    input  logic       accept,
    input  res_t       res,
    input  logic       take,
    input  logic [7:0] rx_rdata,
    output logic       can_accept,
    output logic       m_valid,
    input  logic       m_ready,
    output res_t       m_res,
    output logic [7:0] m_rx_byte
);

    logic       pend_v_reg, pend_v_next;
    logic       m_v_reg, m_v_next;
    res_t       pend_res_reg;
    logic       pend_take_reg;
    res_t       m_res_reg;
    logic [7:0] rx_byte_reg;
    logic       move;

    // pending slot holds the result while the registered receive buffer read completes
    assign move        = pend_v_reg && (!m_v_reg || m_ready);
    assign can_accept  = !pend_v_reg || !m_v_reg || m_ready;
    assign pend_v_next = accept || (pend_v_reg && !move);
    assign m_v_next    = move || (m_v_reg && !m_ready);

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            pend_v_reg <= 1'b0;
            m_v_reg    <= 1'b0;
        end else begin
            pend_v_reg <= pend_v_next;
            m_v_reg    <= m_v_next;
        end
    end

    always_ff @(posedge aclk) begin
        if (accept) begin
            pend_res_reg  <= res;
            pend_take_reg <= take;
        end
        if (move) begin
            m_res_reg   <= pend_res_reg;
            rx_byte_reg <= pend_take_reg ? rx_rdata : 8'd0;
        end
    end

    assign m_valid   = m_v_reg;
    assign m_res     = m_res_reg;
    assign m_rx_byte = rx_byte_reg;

    a_accept_fills: assert property (@(posedge aclk) disable iff (!aresetn)
        accept |=> pend_v_reg)
        else $error("accepted transaction lost before the output register");

endmodule

[design/i2c_bitbang_master.sv]
// Open-drain I2C master driven by a stream of items. Each accepted item gives
// exactly one result. Action 0 is a time base tick that advances the bus
// sequencer (start, address, data bytes with ack slots, stop), actions 1 to 5
// open a write, queue a byte, launch the write, launch a read or take a received
// byte; while a bus transaction runs, commands have no effect. cfg_wr_data sets
// how many ticks make one wait unit of the bus timing (zero acts as one) and may
// be written only while the block is idle. Rate: one item per clock cycle while
// the output is not stalled; each result passes through a pending slot and an
// output register. The transmit queue and receive buffer are single-port-write
// RAMs with a registered read; all other state lives in flops. A taken byte is
// read from the receive buffer on the accepting edge and joins its result as it
// moves from the pending slot to the output register; the next byte to send is
// prefetched from the transmit queue while a byte is on the wire. No clearing
// pass is needed after reset: buffer entries are only used after being written.
module i2c_bitbang_master import i2cbb_pkg::*; #(
    parameter int BUFFER_DEPTH = BUFFER_DEPTH_DEF
) (
    input  logic              aclk,
    input  logic              aresetn,
    // command and tick transactions
    input  logic              s_valid,
    output logic              s_ready,
    input  logic [2:0]        s_action,
    input  logic [7:0]        s_data_byte,
    input  logic [6:0]        s_address,
    input  logic [5:0]        s_count,
    input  logic              s_sda_in,
    input  logic              s_scl_in,
    // result transactions
    output logic              m_valid,
    input  logic              m_ready,
    output logic              m_scl_low,
    output logic              m_sda_low,
    output logic              m_busy_res,
    output logic              m_done_res,
    output logic [1:0]        m_status,
    output logic [5:0]        m_read_count,
    output logic [7:0]        m_rx_byte,
    output logic [5:0]        m_rx_left,
    output logic [5:0]        m_tx_level,
    // wait unit register
    input  logic              cfg_wr_en,
    input  logic [WAIT_W-1:0] cfg_wr_data
);

    localparam int IDX_W = (BUFFER_DEPTH > 1) ? $clog2(BUFFER_DEPTH) : 1;

    logic             accept;
    logic             can_accept;

    // buffer ports
    logic             tx_we;
    logic [IDX_W-1:0] tx_waddr;
    logic [7:0]       tx_wdata;
    logic [IDX_W-1:0] tx_raddr;
    logic [7:0]       tx_rdata;
    logic             rx_we;
    logic [IDX_W-1:0] rx_waddr;
    logic [7:0]       rx_wdata;
    logic             rx_re;
    logic [IDX_W-1:0] rx_raddr;
    logic [7:0]       rx_rdata;

    res_t             res;
    res_t             m_res;
    logic             take;

    // a new transaction enters whenever the result stage has a free slot
    assign s_ready = can_accept;
    assign accept  = s_valid && can_accept;

    // sequencer, command decode and all scalar state
    i2cbb_seq #(
        .BUFFER_DEPTH (BUFFER_DEPTH)
    ) u_seq (
        .aclk        (aclk),
        .aresetn     (aresetn),
        .accept      (accept),
        .s_action    (s_action),
        .s_data_byte (s_data_byte),
        .s_address   (s_address),
        .s_count     (s_count),
        .s_sda_in    (s_sda_in),
        .s_scl_in    (s_scl_in),
        .cfg_wr_en   (cfg_wr_en),
        .cfg_wr_data (cfg_wr_data),
        .tx_we       (tx_we),
        .tx_waddr    (tx_waddr),
        .tx_wdata    (tx_wdata),
        .tx_raddr    (tx_raddr),
        .tx_rdata    (tx_rdata),
        .rx_we       (rx_we),
        .rx_waddr    (rx_waddr),
        .rx_wdata    (rx_wdata),
        .rx_re       (rx_re),
        .rx_raddr    (rx_raddr),
        .res         (res),
        .take        (take)
    );

    // transmit queue, read every cycle at the prefetch address
    i2cbb_ram #(
        .WIDTH (8),
        .DEPTH (BUFFER_DEPTH)
    ) u_tx_ram (
        .aclk  (aclk),
        .we    (tx_we),
        .waddr (tx_waddr),
        .wdata (tx_wdata),
        .re    (1'b1),
        .raddr (tx_raddr),
        .rdata (tx_rdata)
    );

    // receive buffer, read only on a take so the data holds while the result stalls
    i2cbb_ram #(
        .WIDTH (8),
        .DEPTH (BUFFER_DEPTH)
    ) u_rx_ram (
        .aclk  (aclk),
        .we    (rx_we),
        .waddr (rx_waddr),
        .wdata (rx_wdata),
        .re    (rx_re),
        .raddr (rx_raddr),
        .rdata (rx_rdata)
    );

    // pending slot plus output register
    i2cbb_out u_out (
        .aclk       (aclk),
        .aresetn    (aresetn),
        .accept     (accept),
        .res        (res),
        .take       (take),
        .rx_rdata   (rx_rdata),
        .can_accept (can_accept),
        .m_valid    (m_valid),
        .m_ready    (m_ready),
        .m_res      (m_res),
        .m_rx_byte  (m_rx_byte)
    );

    assign m_scl_low    = m_res.scl_low;
    assign m_sda_low    = m_res.sda_low;
    assign m_busy_res   = m_res.busy;
    assign m_done_res   = m_res.done;
    assign m_status     = m_res.status;
    assign m_read_count = m_res.read_count;
    assign m_rx_left    = m_res.rx_left;
    assign m_tx_level   = m_res.tx_level;

endmodule
